// File: rtl/core/mdlt_pkg.sv
// Shared types and constants of the make dependency line tokenizer.
// No dependencies; every other file except mdlt_checker imports this package.
`default_nettype none
package mdlt_pkg;

   localparam int unsigned CAP_W      = 16;
   localparam int unsigned NAME_LEN_W = 16;
   localparam int unsigned MAX_RES    = 3;
   localparam int unsigned RES_DEPTH  = 4;
   localparam int unsigned RES_PTR_W  = $clog2(RES_DEPTH);
   localparam int unsigned RES_CNT_W  = $clog2(RES_DEPTH + 1);

   localparam logic [CAP_W-1:0] CAP_RESET = 16'd4096;

   localparam logic [2:0] PH_LEAD    = 3'd0;
   localparam logic [2:0] PH_TARGET  = 3'd1;
   localparam logic [2:0] PH_AFTER   = 3'd2;
   localparam logic [2:0] PH_BETWEEN = 3'd3;
   localparam logic [2:0] PH_DEP     = 3'd4;

   localparam logic [1:0] PEND_NONE   = 2'd0;
   localparam logic [1:0] PEND_BSL    = 2'd1;
   localparam logic [1:0] PEND_DOLLAR = 2'd2;
   localparam logic [1:0] PEND_CR     = 2'd3;

   localparam logic [1:0] ST_RUN      = 2'd0;
   localparam logic [1:0] ST_OK       = 2'd1;
   localparam logic [1:0] ST_SYNTAX   = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_BSL    = 8'h5C;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       token_end;
      logic       is_target;
      logic [1:0] status;
      logic       run_last;
   } res_type;

endpackage
`default_nettype wire

// File: rtl/core/make_dependency_line_tokenizer_unit.sv
// A byte accepted is held in the item register, decoded, and written into the result queue.
// Throughput: one byte per cycle while each byte yields at most one item and rsp_tready
// stays high; a byte with two or three items holds input until the 4-entry result queue
// has room, since the queue drains at most one item per cycle.
// Reset: parser to leading blanks before the target, capacity 4096, queue empty.
// Top level; depends on mdlt_pkg, mdlt_step and mdlt_res_fifo.
`default_nettype none
module make_dependency_line_tokenizer_unit
   import mdlt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,   // [7:0] in_byte
   input  wire logic              req_tlast,   // last_byte
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [15:0]            rsp_tdata,   // [7:0] out_byte, [9:8] status
   output logic [2:0]             rsp_tuser,   // [0] byte_valid, [1] token_end, [2] is_target
   output logic                   rsp_tlast,   // run_last
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CAP_W-1:0]  csr_data    // name_capacity
);

   logic                  item_valid_ff, item_valid_in;
   logic [7:0]            item_byte_ff, item_byte_in;
   logic                  item_last_ff, item_last_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic                  req_take;
   logic                  fire;
   logic                  pop;
   res_type [MAX_RES-1:0] step_res;
   logic [1:0]            step_cnt;
   logic [1:0]            push_cnt;
   logic [RES_CNT_W-1:0]  room;
   res_type               head;

   mdlt_step u_step (
      .clock    (clock),
      .reset    (reset),
      .in_byte  (item_byte_ff),
      .in_last  (item_last_ff),
      .capacity (cap_ff),
      .fire     (fire),
      .res      (step_res),
      .res_cnt  (step_cnt)
   );

   mdlt_res_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push_data (step_res),
      .pop       (pop),
      .rd_valid  (rsp_tvalid),
      .rd_data   (head),
      .room      (room)
   );

   always_comb begin
      fire          = item_valid_ff && (RES_CNT_W'(step_cnt) <= room);
      push_cnt      = fire ? step_cnt : 2'd0;
      req_tready    = !item_valid_ff || fire;
      req_take      = req_tvalid && req_tready;
      pop           = rsp_tvalid && rsp_tready;
      item_valid_in = req_take || (item_valid_ff && !fire);
      item_byte_in  = req_take ? req_tdata : item_byte_ff;
      item_last_in  = req_take ? req_tlast : item_last_ff;
      csr_ready     = 1'b1;
      cap_in        = csr_valid ? csr_data : cap_ff;
      rsp_tdata     = {6'b0, head.status, head.out_byte};
      rsp_tuser     = {head.is_target, head.token_end, head.byte_valid};
      rsp_tlast     = head.run_last;
   end

   always_ff @(posedge clock) begin
      item_byte_ff <= item_byte_in;
      item_last_ff <= item_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         cap_ff        <= CAP_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         cap_ff        <= cap_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/mdlt_step.sv
// Parser state and the single-pass decode of one byte into up to three items.
// Depends on mdlt_pkg.
`default_nettype none
module mdlt_step
   import mdlt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [7:0]           in_byte,
   input  wire logic                 in_last,
   input  wire logic [CAP_W-1:0]     capacity,
   input  wire logic                 fire,
   output res_type [MAX_RES-1:0]     res,
   output logic [1:0]                res_cnt
);

   typedef struct packed {
      logic [2:0]            ph;
      logic [1:0]            pe;
      logic [NAME_LEN_W-1:0] nl;
      logic [1:0]            fin;
      logic [1:0]            cnt;
      res_type [MAX_RES-1:0] res;
   } ctx_type;

   logic [2:0]            ph_ff, ph_in;
   logic [1:0]            pe_ff, pe_in;
   logic [NAME_LEN_W-1:0] nl_ff, nl_in;
   logic [1:0]            fin_ff, fin_in;
   ctx_type               cur, nxt;

   function automatic logic is_blank(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic ctx_type put_res(ctx_type x, logic [7:0] b, logic v, logic e,
                                       logic t, logic [1:0] st);
      res_type r;
      r.out_byte   = b;
      r.byte_valid = v;
      r.token_end  = e;
      r.is_target  = t;
      r.status     = st;
      r.run_last   = 1'b0;
      if (x.cnt != 2'd3) begin
         x.res[x.cnt] = r;
         x.cnt        = x.cnt + 2'd1;
      end
      return x;
   endfunction

   function automatic ctx_type finish(ctx_type x, logic [1:0] st);
      logic [1:0] k;
      k = x.cnt - 2'd1;
      if (x.fin == ST_RUN) begin
         x.fin = st;
         if ((x.cnt != 2'd0) && x.res[k].token_end) begin
            x.res[k].status = st;
         end else begin
            x = put_res(x, 8'h00, 1'b0, 1'b0, 1'b0, st);
         end
      end
      return x;
   endfunction

   function automatic ctx_type name_add(ctx_type x, logic [7:0] c, logic [CAP_W-1:0] cap);
      if (x.fin == ST_RUN) begin
         if (x.nl >= cap) begin
            x = finish(x, ST_OVERFLOW);
         end else begin
            x    = put_res(x, c, 1'b1, 1'b0, x.ph == PH_TARGET, ST_RUN);
            x.nl = x.nl + 16'd1;
         end
      end
      return x;
   endfunction

   function automatic ctx_type name_close(ctx_type x, logic [CAP_W-1:0] cap);
      if (x.fin == ST_RUN) begin
         if (x.nl == '0) begin
            x = finish(x, ST_SYNTAX);
         end else if (x.nl >= cap) begin
            x = finish(x, ST_OVERFLOW);
         end else begin
            x = put_res(x, 8'h00, 1'b0, 1'b1, x.ph == PH_TARGET, ST_RUN);
         end
      end
      return x;
   endfunction

   function automatic ctx_type after_target(ctx_type x, logic [7:0] c);
      if (!is_blank(c)) begin
         if (c == CH_COLON) begin
            x.ph = PH_BETWEEN;
         end else begin
            x = finish(x, ST_SYNTAX);
         end
      end
      return x;
   endfunction

   function automatic ctx_type name_fresh(ctx_type x, logic [7:0] c, logic [CAP_W-1:0] cap);
      if (is_blank(c) || (c == CH_COLON) || (c == CH_LF) || (c == CH_CR)) begin
         x = name_close(x, cap);
         if (x.fin == ST_RUN) begin
            if (x.ph == PH_TARGET) begin
               x.ph = PH_AFTER;
               x    = after_target(x, c);
            end else begin
               x.ph = PH_BETWEEN;
               if (c == CH_COLON) begin
                  x = finish(x, ST_SYNTAX);
               end else if ((c == CH_LF) || (c == CH_CR)) begin
                  x = finish(x, ST_OK);
               end
            end
         end
      end else if (c == CH_BSL) begin
         x.pe = PEND_BSL;
      end else if (c == CH_DOLLAR) begin
         x.pe = PEND_DOLLAR;
      end else begin
         x = name_add(x, c, cap);
      end
      return x;
   endfunction

   function automatic ctx_type name_byte(ctx_type x, logic [7:0] c, logic [CAP_W-1:0] cap);
      logic [1:0] p;
      p    = x.pe;
      x.pe = PEND_NONE;
      if (p == PEND_BSL) begin
         if ((c == CH_SPACE) || (c == CH_BSL) || (c == CH_HASH)) begin
            x = name_add(x, c, cap);
         end else if ((c == CH_LF) || (c == CH_CR)) begin
            x = finish(x, ST_SYNTAX);
         end else begin
            x = name_add(x, CH_BSL, cap);
            if (x.fin == ST_RUN) begin
               x = name_fresh(x, c, cap);
            end
         end
      end else if (p == PEND_DOLLAR) begin
         x = name_add(x, CH_DOLLAR, cap);
         if ((c != CH_DOLLAR) && (x.fin == ST_RUN)) begin
            x = name_fresh(x, c, cap);
         end
      end else begin
         x = name_fresh(x, c, cap);
      end
      return x;
   endfunction

   function automatic ctx_type between(ctx_type x, logic [7:0] c, logic [CAP_W-1:0] cap);
      logic [1:0] p;
      p    = x.pe;
      x.pe = PEND_NONE;
      if (p == PEND_BSL) begin
         if (c == CH_CR) begin
            x.pe = PEND_CR;
         end else if (c != CH_LF) begin
            x.ph = PH_DEP;
            x.nl = '0;
            x.pe = PEND_BSL;
            x    = name_byte(x, c, cap);
         end
      end else if (!((p == PEND_CR) && (c == CH_LF)) && !is_blank(c)) begin
         if (c == CH_BSL) begin
            x.pe = PEND_BSL;
         end else if ((c == CH_LF) || (c == CH_CR) || (c == CH_NUL) || (c == CH_HASH)) begin
            x = finish(x, ST_OK);
         end else if (c == CH_COLON) begin
            x = finish(x, ST_SYNTAX);
         end else begin
            x.ph = PH_DEP;
            x.nl = '0;
            x    = name_fresh(x, c, cap);
         end
      end
      return x;
   endfunction

   function automatic ctx_type lead(ctx_type x, logic [7:0] c, logic [CAP_W-1:0] cap);
      if (!is_blank(c)) begin
         x.ph = PH_TARGET;
         x.nl = '0;
         x.pe = PEND_NONE;
         x    = name_fresh(x, c, cap);
      end
      return x;
   endfunction

   function automatic ctx_type flush_and_close(ctx_type x, logic [CAP_W-1:0] cap);
      logic [1:0] p;
      p    = x.pe;
      x.pe = PEND_NONE;
      if (p == PEND_BSL) begin
         x = name_add(x, CH_BSL, cap);
      end else if (p == PEND_DOLLAR) begin
         x = name_add(x, CH_DOLLAR, cap);
      end
      x = name_close(x, cap);
      return x;
   endfunction

   function automatic ctx_type end_of_input(ctx_type x, logic [CAP_W-1:0] cap);
      if (x.fin == ST_RUN) begin
         if (x.ph == PH_TARGET) begin
            x = flush_and_close(x, cap);
            x = finish(x, ST_SYNTAX);
         end else if (x.ph == PH_BETWEEN) begin
            if (x.pe == PEND_BSL) begin
               x.ph = PH_DEP;
               x.nl = '0;
               x    = flush_and_close(x, cap);
            end
            x = finish(x, ST_OK);
         end else if (x.ph == PH_DEP) begin
            x = flush_and_close(x, cap);
            x = finish(x, ST_OK);
         end else begin
            x = finish(x, ST_SYNTAX);
         end
      end
      return x;
   endfunction

   function automatic ctx_type step(ctx_type x, logic [7:0] c, logic last,
                                    logic [CAP_W-1:0] cap);
      logic [1:0] k;
      x.cnt = 2'd0;
      x.res = '0;
      if (x.fin == ST_RUN) begin
         case (x.ph) inside
            PH_TARGET, PH_DEP: x = name_byte(x, c, cap);
            PH_AFTER:          x = after_target(x, c);
            PH_BETWEEN:        x = between(x, c, cap);
            default:           x = lead(x, c, cap);
         endcase
         if (last) begin
            x = end_of_input(x, cap);
         end
      end
      if (last) begin
         x.ph  = PH_LEAD;
         x.pe  = PEND_NONE;
         x.nl  = '0;
         x.fin = ST_RUN;
      end
      k = x.cnt - 2'd1;
      if (x.cnt != 2'd0) begin
         x.res[k].run_last = 1'b1;
      end
      return x;
   endfunction

   always_comb begin
      cur     = '0;
      cur.ph  = ph_ff;
      cur.pe  = pe_ff;
      cur.nl  = nl_ff;
      cur.fin = fin_ff;
      nxt     = step(cur, in_byte, in_last, capacity);
      res     = nxt.res;
      res_cnt = nxt.cnt;
      ph_in   = fire ? nxt.ph  : ph_ff;
      pe_in   = fire ? nxt.pe  : pe_ff;
      nl_in   = fire ? nxt.nl  : nl_ff;
      fin_in  = fire ? nxt.fin : fin_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff  <= PH_LEAD;
         pe_ff  <= PEND_NONE;
         nl_ff  <= '0;
         fin_ff <= ST_RUN;
      end else begin
         ph_ff  <= ph_in;
         pe_ff  <= pe_in;
         nl_ff  <= nl_in;
         fin_ff <= fin_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/mdlt_res_fifo.sv
// Result queue: takes up to three items per cycle, delivers one per cycle when popped.
// Depends on mdlt_pkg.
`default_nettype none
module mdlt_res_fifo
   import mdlt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [1:0]           push_cnt,
   input  wire res_type [MAX_RES-1:0] push_data,
   input  wire logic                 pop,
   output logic                      rd_valid,
   output res_type                   rd_data,
   output logic [RES_CNT_W-1:0]      room
);

   res_type                mem_ff [RES_DEPTH];
   res_type                mem_in [RES_DEPTH];
   logic [RES_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RES_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RES_CNT_W-1:0]   count_ff, count_in;
   logic [RES_CNT_W-1:0]   count_after;

   always_comb begin
      count_after = count_ff - RES_CNT_W'(pop);
      room        = RES_CNT_W'(RES_DEPTH) - count_after;
      count_in    = count_after + RES_CNT_W'(push_cnt);
      wr_ptr_in   = wr_ptr_ff + RES_PTR_W'(push_cnt);
      rd_ptr_in   = rd_ptr_ff + RES_PTR_W'(pop);
      rd_valid    = (count_ff != '0);
      rd_data     = mem_ff[rd_ptr_ff];
      mem_in      = mem_ff;
      for (int i = 0; i < MAX_RES; i++) begin
         if (2'(i) < push_cnt) begin
            mem_in[wr_ptr_ff + RES_PTR_W'(i)] = push_data[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/mdlt_checker.sv
// Port-level checks of the tokenizer, bound to the top level.
// Depends on make_dependency_line_tokenizer_unit's port list only.
`default_nettype none
module mdlt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("req_tready low after reset");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_byte_running: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[9:8] == 2'd0) && !rsp_tuser[1])
      else $error("name byte item carries status or token end");

endmodule

bind make_dependency_line_tokenizer_unit mdlt_checker u_mdlt_checker (.*);
`default_nettype wire

// File: tb/sv/make_dependency_line_tokenizer_unit_test.sv
// Self-checking testbench for make_dependency_line_tokenizer_unit: streams make
// rule bytes, predicts every result item, and checks them in order.
// Depends on mdlt_pkg and the tokenizer RTL.
module make_dependency_line_tokenizer_unit_test;
   import mdlt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_BYTES  = 150;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 12;
   localparam int MAX_REPORTS   = 40;

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = 8'h00;
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [15:0]       rsp_tdata;
   logic [2:0]        rsp_tuser;
   logic              rsp_tlast;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [CAP_W-1:0]  csr_data   = '0;

   make_dependency_line_tokenizer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // tokenizer shadow state
   logic [CAP_W-1:0]      capacity;
   logic [2:0]            phase;
   logic [1:0]            pending;
   logic [NAME_LEN_W-1:0] name_len;
   logic [1:0]            run_state;
   res_type               step_items [MAX_RES];
   int                    step_count;
   res_type               expected_items [$];

   logic [7:0] rule_bytes [$];
   bit         idle_on = 1'b1;
   bit         rsp_hold = 1'b0;
   int         errors = 0;
   int         bytes_accepted = 0;
   int         items_checked = 0;
   int         runs_sent = 0;
   int         end_counts [4] = '{0, 0, 0, 0};
   int         cycles = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d items still expected", $time, expected_items.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   function automatic void emit_item(logic [7:0] b, logic v, logic e, logic t, logic [1:0] st);
      res_type r;
      if (step_count >= int'(MAX_RES))
         return;
      r = '0;
      r.out_byte   = b;
      r.byte_valid = v;
      r.token_end  = e;
      r.is_target  = t;
      r.status     = st;
      step_items[step_count] = r;
      step_count++;
   endfunction

   function automatic void end_run(logic [1:0] st);
      if (run_state != ST_RUN)
         return;
      run_state = st;
      if (step_count > 0 && step_items[step_count-1].token_end)
         step_items[step_count-1].status = st;
      else
         emit_item(8'h00, 1'b0, 1'b0, 1'b0, st);
   endfunction

   function automatic void append_name(logic [7:0] c);
      if (run_state != ST_RUN)
         return;
      if (name_len >= capacity) begin
         end_run(ST_OVERFLOW);
         return;
      end
      emit_item(c, 1'b1, 1'b0, phase == PH_TARGET, ST_RUN);
      name_len = name_len + 1'b1;
   endfunction

   function automatic void close_name();
      if (run_state != ST_RUN)
         return;
      if (name_len == 0)
         end_run(ST_SYNTAX);
      else if (name_len >= capacity)
         end_run(ST_OVERFLOW);
      else
         emit_item(8'h00, 1'b0, 1'b1, phase == PH_TARGET, ST_RUN);
   endfunction

   function automatic void after_target(logic [7:0] c);
      if (is_blank(c))
         return;
      if (c == CH_COLON)
         phase = PH_BETWEEN;
      else
         end_run(ST_SYNTAX);
   endfunction

   function automatic void plain_name_byte(logic [7:0] c);
      if (is_blank(c) || c == CH_COLON || c == CH_LF || c == CH_CR) begin
         close_name();
         if (run_state != ST_RUN)
            return;
         if (phase == PH_TARGET) begin
            phase = PH_AFTER;
            after_target(c);
         end else begin
            phase = PH_BETWEEN;
            if (c == CH_COLON)
               end_run(ST_SYNTAX);
            else if (c == CH_LF || c == CH_CR)
               end_run(ST_OK);
         end
      end else if (c == CH_BSL) begin
         pending = PEND_BSL;
      end else if (c == CH_DOLLAR) begin
         pending = PEND_DOLLAR;
      end else begin
         append_name(c);
      end
   endfunction

   function automatic void name_byte(logic [7:0] c);
      logic [1:0] p;
      p = pending;
      pending = PEND_NONE;
      if (p == PEND_BSL) begin
         if (c == CH_SPACE || c == CH_BSL || c == CH_HASH) begin
            append_name(c);
         end else if (c == CH_LF || c == CH_CR) begin
            end_run(ST_SYNTAX);
         end else begin
            append_name(CH_BSL);
            if (run_state == ST_RUN)
               plain_name_byte(c);
         end
      end else if (p == PEND_DOLLAR) begin
         append_name(CH_DOLLAR);
         if (c != CH_DOLLAR && run_state == ST_RUN)
            plain_name_byte(c);
      end else begin
         plain_name_byte(c);
      end
   endfunction

   function automatic void between_byte(logic [7:0] c);
      logic [1:0] p;
      p = pending;
      pending = PEND_NONE;
      if (p == PEND_BSL) begin
         if (c == CH_LF)
            return;
         if (c == CH_CR) begin
            pending = PEND_CR;
            return;
         end
         phase = PH_DEP;
         name_len = '0;
         pending = PEND_BSL;
         name_byte(c);
         return;
      end
      if (p == PEND_CR && c == CH_LF)
         return;
      if (is_blank(c))
         return;
      if (c == CH_BSL) begin
         pending = PEND_BSL;
      end else if (c == CH_LF || c == CH_CR || c == CH_NUL || c == CH_HASH) begin
         end_run(ST_OK);
      end else if (c == CH_COLON) begin
         end_run(ST_SYNTAX);
      end else begin
         phase = PH_DEP;
         name_len = '0;
         plain_name_byte(c);
      end
   endfunction

   function automatic void lead_byte(logic [7:0] c);
      if (is_blank(c))
         return;
      phase = PH_TARGET;
      name_len = '0;
      pending = PEND_NONE;
      plain_name_byte(c);
   endfunction

   function automatic void flush_and_close();
      logic [1:0] p;
      p = pending;
      pending = PEND_NONE;
      if (p == PEND_BSL)
         append_name(CH_BSL);
      else if (p == PEND_DOLLAR)
         append_name(CH_DOLLAR);
      close_name();
   endfunction

   function automatic void end_of_file();
      if (run_state != ST_RUN)
         return;
      if (phase == PH_TARGET) begin
         flush_and_close();
         end_run(ST_SYNTAX);
      end else if (phase == PH_BETWEEN) begin
         if (pending == PEND_BSL) begin
            phase = PH_DEP;
            name_len = '0;
            flush_and_close();
         end
         end_run(ST_OK);
      end else if (phase == PH_DEP) begin
         flush_and_close();
         end_run(ST_OK);
      end else begin
         end_run(ST_SYNTAX);
      end
   endfunction

   function automatic void clear_parser();
      phase = PH_LEAD;
      pending = PEND_NONE;
      name_len = '0;
      run_state = ST_RUN;
   endfunction

   function automatic void tokenize_byte(logic [7:0] c, logic fin);
      step_count = 0;
      if (run_state == ST_RUN) begin
         case (phase)
            PH_TARGET, PH_DEP: name_byte(c);
            PH_AFTER:          after_target(c);
            PH_BETWEEN:        between_byte(c);
            default:           lead_byte(c);
         endcase
         if (fin)
            end_of_file();
      end
      if (fin)
         clear_parser();
      if (step_count > 0)
         step_items[step_count-1].run_last = 1'b1;
      for (int i = 0; i < step_count; i++)
         expected_items.push_back(step_items[i]);
   endfunction

   always @(negedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         bytes_accepted++;
         tokenize_byte(req_tdata, req_tlast);
      end
   end

   always @(negedge clock) begin
      res_type got;
      res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '0;
         got.out_byte   = rsp_tdata[7:0];
         got.status     = rsp_tdata[9:8];
         got.byte_valid = rsp_tuser[0];
         got.token_end  = rsp_tuser[1];
         got.is_target  = rsp_tuser[2];
         got.run_last   = rsp_tlast;
         items_checked++;
         if (got.status != ST_RUN)
            end_counts[got.status]++;
         if (expected_items.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected item byte=%02h v=%b end=%b tgt=%b st=%0d last=%b",
                        $time, got.out_byte, got.byte_valid, got.token_end, got.is_target,
                        got.status, got.run_last);
         end else begin
            want = expected_items.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: exp %02h/%b%b%b/%0d/%b got %02h/%b%b%b/%0d/%b",
                           $time, want.out_byte, want.byte_valid, want.token_end,
                           want.is_target, want.status, want.run_last,
                           got.out_byte, got.byte_valid, got.token_end, got.is_target,
                           got.status, got.run_last);
            end
         end
      end
   end

   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            n = pick_gap();
            rsp_tready <= 1'b0;
            repeat (n == 0 ? 1 : n) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
               @(posedge clock);
               if (rsp_hold)
                  break;
            end
         end
      end
   end

   task automatic send_byte(logic [7:0] b, logic fin);
      int gap;
      bit hs;
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do begin
         @(negedge clock);
         hs = req_tready;
         @(posedge clock);
      end while (!hs);
   endtask

   task automatic send_rule();
      for (int i = 0; i < rule_bytes.size(); i++)
         send_byte(rule_bytes[i], i == rule_bytes.size() - 1);
      rule_bytes.delete();
      runs_sent++;
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++)
         rule_bytes.push_back(s[i]);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_items.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] v);
      bit hs;
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do begin
         @(negedge clock);
         hs = csr_ready;
         @(posedge clock);
      end while (!hs);
      csr_valid <= 1'b0;
      capacity = v;
   endtask

   task automatic test_plain_rule();
      add_text(" \tout.o :dep1\tdep2  \njunk");
      send_rule();
      wait_drained();
   endtask

   task automatic test_escapes();
      add_text("a\\ b\\\\c\\#d$$e\\x$f$:\\\n g \\");
      rule_bytes.push_back(CH_CR);
      rule_bytes.push_back(CH_LF);
      add_text("h \\ y \\");
      rule_bytes.push_back(CH_CR);
      add_text("i\\");
      rule_bytes.push_back(CH_CR);
      send_rule();
      add_text("ab\\\n");
      send_rule();
      wait_drained();
   endtask

   task automatic test_file_ends();
      add_text("abc");
      send_rule();
      add_text("ab\\");
      send_rule();
      add_text("ab ");
      send_rule();
      add_text("a: \\");
      send_rule();
      add_text("a: b$");
      send_rule();
      add_text("a:");
      send_rule();
      add_text(" ");
      send_rule();
      add_text("a:b");
      rule_bytes.push_back(CH_CR);
      add_text("zz");
      send_rule();
      add_text("x:y ");
      rule_bytes.push_back(CH_NUL);
      add_text("w");
      send_rule();
      add_text("q: #c");
      send_rule();
      wait_drained();
   endtask

   task automatic test_syntax_errors();
      add_text(": a");
      send_rule();
      add_text("\t\n");
      send_rule();
      add_text("a b:");
      send_rule();
      add_text("a: b:");
      send_rule();
      add_text("a: :");
      send_rule();
      add_text("a#b");
      rule_bytes.push_back(CH_NUL);
      add_text("c: d\n");
      send_rule();
      wait_drained();
   endtask

   task automatic test_capacity_limits();
      write_capacity(16'd3);
      add_text("ab: abc d\n");
      send_rule();
      write_capacity(16'd2);
      add_text("abc:");
      send_rule();
      write_capacity(16'd1);
      add_text("a:");
      send_rule();
      write_capacity(16'hFFFF);
      add_text("t:");
      rule_bytes.push_back(8'hFF);
      rule_bytes.push_back(8'h80);
      rule_bytes.push_back(8'h01);
      rule_bytes.push_back(CH_LF);
      send_rule();
      wait_drained();
   endtask

   // hold the result side while rules full of bytes that make two items keep coming
   task automatic test_output_stall();
      idle_on = 1'b0;
      rsp_hold = 1'b1;
      repeat (3) begin
         add_text("t$a$b$c: d$e$f$g h$\n");
         send_rule();
      end
      wait_drained();
      idle_on = 1'b1;
   endtask

   task automatic add_blanks();
      repeat ($urandom_range(1, 3))
         rule_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
   endtask

   task automatic add_name();
      int len;
      logic [7:0] plain;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      repeat (len) begin
         plain = 8'($urandom_range(33, 126));
         case ($urandom_range(0, 19))
            13: rule_bytes.push_back(8'($urandom_range(0, 255)));
            14: add_text("\\ ");
            15: add_text("\\\\");
            16: add_text("\\#");
            17: add_text("$$");
            18: begin
               rule_bytes.push_back(CH_BSL);
               rule_bytes.push_back(plain);
            end
            19: begin
               rule_bytes.push_back(CH_DOLLAR);
               rule_bytes.push_back(plain);
            end
            default: rule_bytes.push_back(plain);
         endcase
      end
   endtask

   task automatic build_random_rule();
      rule_bytes.delete();
      if ($urandom_range(0, 6) == 0) begin
         repeat ($urandom_range(1, 10))
            rule_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 2) == 0)
            add_blanks();
         add_name();
         if ($urandom_range(0, 9) == 0)
            add_blanks();
         if ($urandom_range(0, 14) != 0)
            rule_bytes.push_back(CH_COLON);
         else
            rule_bytes.push_back(8'($urandom_range(0, 255)));
         repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 3))
               0: add_text("\\\n");
               1: begin
                  rule_bytes.push_back(CH_BSL);
                  rule_bytes.push_back(CH_CR);
                  if ($urandom_range(0, 1))
                     rule_bytes.push_back(CH_LF);
               end
               default: add_blanks();
            endcase
            add_name();
         end
         case ($urandom_range(0, 5))
            0: rule_bytes.push_back(CH_LF);
            1: rule_bytes.push_back(CH_CR);
            2: begin
               rule_bytes.push_back(CH_CR);
               rule_bytes.push_back(CH_LF);
            end
            3: begin
               add_blanks();
               rule_bytes.push_back(CH_NUL);
            end
            4: begin
               add_blanks();
               rule_bytes.push_back(CH_HASH);
            end
            default: ;
         endcase
         if ($urandom_range(0, 9) < 3)
            repeat ($urandom_range(1, 3))
               rule_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_random_rules();
      int used;
      logic [CAP_W-1:0] cap;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       cap = 16'hFFFF;
            1:       cap = 16'($urandom_range(2, 6));
            2:       cap = 16'($urandom_range(7, 40));
            default: cap = 16'($urandom_range(1, 65535));
         endcase
         write_capacity(cap);
         used = 0;
         while (used < RANDOM_BYTES / 4) begin
            idle_on = ($urandom_range(0, 4) != 0);
            build_random_rule();
            used += rule_bytes.size();
            send_rule();
         end
      end
      idle_on = 1'b1;
      wait_drained();
   endtask

   initial begin
      capacity = CAP_RESET;
      clear_parser();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_plain_rule();
      test_escapes();
      test_file_ends();
      test_syntax_errors();
      test_capacity_limits();
      test_output_stall();
      test_random_rules();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d bytes in %0d files; checked %0d result items, %0d mismatches.",
               bytes_accepted, runs_sent, items_checked, errors);
      $display("Runs ended ok %0d, syntax error %0d, overflow %0d; capacity 1 to 65535.",
               end_counts[ST_OK], end_counts[ST_SYNTAX], end_counts[ST_OVERFLOW]);
      if (errors == 0 && expected_items.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
